// ===== hw/rtl/tcit_pkg.sv =====
// shared types, codes and constants of the interval timer
`default_nettype none

package tcit_pkg;

    localparam int NUM_COUNTERS_DEF = 3;
    localparam int MAX_COUNTERS     = 3;

    // bus commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_GATE  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // register select code of the control word
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // access modes
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_WORD  = 2'd3;

    // counter modes
    localparam logic [2:0] MODE_INT_ON_TC = 3'd0;
    localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
    localparam logic [2:0] MODE_RATE_GEN  = 3'd2;
    localparam logic [2:0] MODE_SQUARE    = 3'd3;
    localparam logic [2:0] MODE_SW_STROBE = 3'd4;
    localparam logic [2:0] MODE_HW_STROBE = 3'd5;

    localparam logic [31:0] STROBE_IDLE_COUNT = 32'd65535;

    // decoded operation for one counter
    typedef struct packed {
        logic        ctrl;
        logic        wr;
        logic        rd;
        logic        gate;
        logic        tick;
        logic [7:0]  data;
        logic [15:0] ticks;
    } op_t;

    // what one counter reports for the word in flight
    typedef struct packed {
        logic [7:0] rd_byte;
        logic       out_next;
        logic       changed;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcit_counter.sv =====
// one timer counter: state registers and next-state logic
`default_nettype none

module tcit_counter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire tcit_pkg::op_t    op,
    output tcit_pkg::status_t     status
);

    logic [31:0] count_reg,    count_next;
    logic [15:0] reload_reg,   reload_next;
    logic [15:0] holding_reg,  holding_next;
    logic [15:0] latched_reg,  latched_next;
    logic        latch_vld_reg, latch_vld_next;
    logic [2:0]  mode_reg,     mode_next;
    logic [1:0]  access_reg,   access_next;
    logic        bcd_reg,      bcd_next;
    logic        low_next_reg, low_next_next;
    logic        pending_reg,  pending_next;
    logic        running_reg,  running_next;
    logic        gate_reg,     gate_next;
    logic        out_reg,      out_next;
    logic [7:0]  rd_byte;

    always_comb
    begin
        logic        low_sel;
        logic [15:0] val;
        logic [15:0] hold_new;
        logic [31:0] dec;
        logic [31:0] diff;
        logic        tc;
        logic        gv;

        count_next     = count_reg;
        reload_next    = reload_reg;
        holding_next   = holding_reg;
        latched_next   = latched_reg;
        latch_vld_next = latch_vld_reg;
        mode_next      = mode_reg;
        access_next    = access_reg;
        bcd_next       = bcd_reg;
        low_next_next  = low_next_reg;
        pending_next   = pending_reg;
        running_next   = running_reg;
        gate_next      = gate_reg;
        out_next       = out_reg;
        rd_byte        = 8'd0;

        low_sel  = 1'b0;
        val      = latch_vld_reg ? latched_reg : count_reg[15:0];
        hold_new = {op.data, holding_reg[7:0]};
        gv       = op.data[0];
        if (mode_reg == tcit_pkg::MODE_SQUARE)
            dec = {15'd0, op.ticks, 1'b0};
        else
            dec = {16'd0, op.ticks};
        diff = count_reg - dec;
        tc   = (diff == 32'd0) || diff[31];

        if (en && op.ctrl)
        begin
            if (op.data[5:4] == tcit_pkg::ACC_LATCH)
            begin
                latched_next   = count_reg[15:0];
                latch_vld_next = 1'b1;
                low_next_next  = 1'b1;
                pending_next   = 1'b0;
            end
            else
            begin
                mode_next    = op.data[3:1];
                bcd_next     = op.data[0];
                access_next  = op.data[5:4];
                pending_next = 1'b1;
                if (op.data[5:4] == tcit_pkg::ACC_WORD)
                    low_next_next = 1'b1;
            end
        end
        else if (en && op.wr)
        begin
            if (access_reg == tcit_pkg::ACC_LOW)
                low_sel = 1'b1;
            else if (access_reg == tcit_pkg::ACC_WORD)
            begin
                low_sel       = low_next_reg;
                low_next_next = !low_next_reg;
            end
            if (low_sel)
                holding_next = {holding_reg[15:8], op.data};
            else
            begin
                holding_next = hold_new;
                reload_next  = hold_new;
                if (pending_reg)
                begin
                    count_next   = {16'd0, hold_new - 16'd1};
                    pending_next = 1'b0;
                end
            end
            out_next = (mode_reg != tcit_pkg::MODE_INT_ON_TC);
        end
        else if (en && op.rd)
        begin
            if (access_reg == tcit_pkg::ACC_LOW)
            begin
                low_sel        = 1'b1;
                latch_vld_next = 1'b0;
            end
            else if (access_reg == tcit_pkg::ACC_WORD)
            begin
                low_sel       = low_next_reg;
                low_next_next = !low_next_reg;
            end
            if (low_sel)
                rd_byte = val[7:0];
            else
            begin
                latch_vld_next = 1'b0;
                rd_byte        = val[15:8];
            end
        end
        else if (en && op.gate)
        begin
            case (mode_reg)
                tcit_pkg::MODE_INT_ON_TC,
                tcit_pkg::MODE_RATE_GEN,
                tcit_pkg::MODE_SQUARE:    running_next = gv;
                tcit_pkg::MODE_ONE_SHOT,
                tcit_pkg::MODE_HW_STROBE: if (!gate_reg && gv) running_next = 1'b1;
                default:                  running_next = running_reg;
            endcase
            if ((mode_reg == tcit_pkg::MODE_RATE_GEN || mode_reg == tcit_pkg::MODE_SQUARE)
                && !gv)
                out_next = 1'b1;
            if (!gate_reg && gv)
                count_next = {16'd0, reload_reg};
            gate_next = gv;
        end
        else if (en && op.tick && running_reg)
        begin
            // strobe modes: end of the low pulse
            if (mode_reg[2] && !out_reg)
            begin
                out_next     = 1'b1;
                running_next = 1'b0;
                count_next   = tcit_pkg::STROBE_IDLE_COUNT;
            end
            else if (tc)
            begin
                // reload of zero counts as 65536
                count_next = diff + {15'd0, (reload_reg == 16'd0), reload_reg};
                case (mode_reg)
                    tcit_pkg::MODE_INT_ON_TC,
                    tcit_pkg::MODE_ONE_SHOT:  out_next = 1'b1;
                    tcit_pkg::MODE_RATE_GEN:  out_next = 1'b0;
                    tcit_pkg::MODE_SQUARE:    out_next = !out_reg;
                    default:                  out_next = out_reg;
                endcase
            end
            else
            begin
                count_next = diff;
                case (mode_reg)
                    tcit_pkg::MODE_ONE_SHOT,
                    tcit_pkg::MODE_SW_STROBE,
                    tcit_pkg::MODE_HW_STROBE: out_next = 1'b0;
                    tcit_pkg::MODE_RATE_GEN:  out_next = 1'b1;
                    default:                  out_next = out_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            reload_reg    <= '0;
            holding_reg   <= '0;
            latched_reg   <= '0;
            latch_vld_reg <= 1'b0;
            mode_reg      <= tcit_pkg::MODE_SQUARE;
            access_reg    <= tcit_pkg::ACC_WORD;
            bcd_reg       <= 1'b0;
            low_next_reg  <= 1'b1;
            pending_reg   <= 1'b0;
            running_reg   <= 1'b0;
            gate_reg      <= 1'b0;
            out_reg       <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            reload_reg    <= reload_next;
            holding_reg   <= holding_next;
            latched_reg   <= latched_next;
            latch_vld_reg <= latch_vld_next;
            mode_reg      <= mode_next;
            access_reg    <= access_next;
            bcd_reg       <= bcd_next;
            low_next_reg  <= low_next_next;
            pending_reg   <= pending_next;
            running_reg   <= running_next;
            gate_reg      <= gate_next;
            out_reg       <= out_next;
        end
    end

    // bcd flag is kept for the register image only
    assign status.rd_byte  = rd_byte | {7'd0, bcd_reg & 1'b0};
    assign status.out_next = out_next;
    assign status.changed  = out_next ^ out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/three_channel_interval_timer_core.sv =====
// throughput: one word per cycle; a stalled result lets one more word in, then input stalls
// an input register feeds the decode and counter logic, which loads a result register
// the input register takes a new word whenever the result register moves or is empty
// reset: asynchronous, active low; counters return to mode 3, word access, out low
`default_nettype none

module three_channel_interval_timer_core #(
    parameter int NUM_COUNTERS = tcit_pkg::NUM_COUNTERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  reg_select,
    input  wire logic [7:0]  data,
    input  wire logic [1:0]  counter_select,
    input  wire logic [15:0] tick_count,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic             out_level0,
    output logic             out_level1,
    output logic             out_level2,
    output logic [2:0]       out_changed
);

    localparam int MaxCnt = tcit_pkg::MAX_COUNTERS;

    // input register
    logic        in_vld_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  reg_sel_reg;
    logic [7:0]  data_reg;
    logic [1:0]  cnt_sel_reg;
    logic [15:0] ticks_reg;

    // result register
    logic        out_vld_reg;
    logic [7:0]  rd_reg,  rd_next;
    logic [2:0]  lvl_reg, lvl_next;
    logic [2:0]  chg_reg, chg_next;

    logic              advance;
    logic              in_take;
    tcit_pkg::status_t status [MaxCnt];

    // the word in the input register executes when the result register can load
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= command;
            reg_sel_reg <= reg_select;
            data_reg    <= data;
            cnt_sel_reg <= counter_select;
            ticks_reg   <= tick_count;
        end
    end

    // per-counter decode; counters at or above NUM_COUNTERS are absent and read as zero
    for (genvar i = 0; i < MaxCnt; i++)
    begin : g_cnt
        if (i < NUM_COUNTERS)
        begin : g_on
            tcit_pkg::op_t op;

            always_comb
            begin
                op.ctrl  = (cmd_reg == tcit_pkg::CMD_WRITE)
                        && (reg_sel_reg == tcit_pkg::REG_CONTROL)
                        && (data_reg[7:6] == 2'(i));
                op.wr    = (cmd_reg == tcit_pkg::CMD_WRITE) && (reg_sel_reg == 2'(i));
                op.rd    = (cmd_reg == tcit_pkg::CMD_READ) && (reg_sel_reg == 2'(i));
                op.gate  = (cmd_reg == tcit_pkg::CMD_GATE) && (cnt_sel_reg == 2'(i));
                op.tick  = (cmd_reg == tcit_pkg::CMD_TICK) && (ticks_reg != 16'd0);
                op.data  = data_reg;
                op.ticks = ticks_reg;
            end

            tcit_counter u_counter (
                .clk    (clk),
                .rst_n  (rst_n),
                .en     (advance),
                .op     (op),
                .status (status[i])
            );
        end
        else
        begin : g_off
            assign status[i] = '0;
        end
    end

    // merge counter reports; only the addressed counter drives a nonzero read byte
    always_comb
    begin
        rd_next = 8'd0;
        for (int k = 0; k < MaxCnt; k++)
        begin
            rd_next     = rd_next | status[k].rd_byte;
            lvl_next[k] = status[k].out_next;
            chg_next[k] = status[k].changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
            chg_reg <= chg_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign read_data   = rd_reg;
    assign out_level0  = lvl_reg[0];
    assign out_level1  = lvl_reg[1];
    assign out_level2  = lvl_reg[2];
    assign out_changed = chg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcit_checker.sv =====
// port-level checks of the interval timer, bound to the top level
`default_nettype none

module tcit_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  command,
    input wire logic [1:0]  reg_select,
    input wire logic [7:0]  data,
    input wire logic [1:0]  counter_select,
    input wire logic [15:0] tick_count,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  read_data,
    input wire logic        out_level0,
    input wire logic        out_level1,
    input wire logic        out_level2,
    input wire logic [2:0]  out_changed
);

    logic [2:0] lvl;
    logic [2:0] last_lvl_reg;
    logic       unused;

    assign lvl    = {out_level2, out_level1, out_level0};
    assign unused = ^{command, reg_select, data, counter_select, tick_count, in_valid};

    // out levels as of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_lvl_reg <= 3'd0;
        else if (out_valid && !out_stall)
            last_lvl_reg <= lvl;
    end

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(out_changed)
            && $stable(lvl))
        else $error("result word changed while stalled");

    // the change mask agrees with the level history
    a_chg_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> (lvl ^ last_lvl_reg) == out_changed)
        else $error("out_changed disagrees with out levels");

    // a read never moves OUT, and only reads return data
    a_rd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_changed == 3'd0) || (read_data == 8'd0))
        else $error("read data alongside out change");

    // the input side stalls only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result path free");

endmodule

bind three_channel_interval_timer_core tcit_checker u_tcit_checker (.*);

`default_nettype wire

// ===== tb/sv/tcit_result_checker.sv =====
// result checker of the interval timer: predicts every result word and compares it
`default_nettype none

module tcit_result_checker #(
    parameter int NUM_COUNTERS = tcit_pkg::NUM_COUNTERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  reg_select,
    input  wire logic [7:0]  data,
    input  wire logic [1:0]  counter_select,
    input  wire logic [15:0] tick_count,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  read_data,
    input  wire logic        out_level0,
    input  wire logic        out_level1,
    input  wire logic        out_level2,
    input  wire logic [2:0]  out_changed,
    output int               mismatch_count,
    output int               words_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] READ_BACK_SEL = 2'd3;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       lvl0;
        logic       lvl1;
        logic       lvl2;
        logic [2:0] changed;
    } timer_result_t;

    // per-counter image of the timer
    logic [31:0] count_q      [3];
    logic [15:0] reload_q     [3];
    logic [15:0] hold_q       [3];
    logic [15:0] snap_q       [3];
    logic        snap_valid   [3];
    logic [2:0]  mode_q       [3];
    logic [1:0]  access_q     [3];
    logic        bcd_q        [3];
    logic        low_next     [3];
    logic        load_pending [3];
    logic        running      [3];
    logic        gate_q       [3];
    logic        out_q        [3];
    logic [2:0]  changed_now;

    timer_result_t expected_results [$];
    int            fails;

    assign mismatch_count = fails;

    function automatic void move_out(int i, logic v);
        if (out_q[i] != v)
        begin
            out_q[i]       = v;
            changed_now[i] = 1'b1;
        end
    endfunction

    function automatic timer_result_t timer_predict(logic [1:0] cmd, logic [1:0] rsel,
                                                    logic [7:0] d, logic [1:0] csel,
                                                    logic [15:0] ticks);
        timer_result_t r;
        int            i;
        logic          lo;
        logic [15:0]   val;
        logic [2:0]    m;
        r           = '0;
        changed_now = '0;
        case (cmd)
            tcit_pkg::CMD_WRITE:
            begin
                if (rsel == tcit_pkg::REG_CONTROL)
                begin
                    i = d[7:6];
                    if (d[7:6] != READ_BACK_SEL && i < NUM_COUNTERS)
                    begin
                        if (d[5:4] == tcit_pkg::ACC_LATCH)
                        begin
                            snap_q[i]       = count_q[i][15:0];
                            snap_valid[i]   = 1'b1;
                            low_next[i]     = 1'b1;
                            load_pending[i] = 1'b0;
                        end
                        else
                        begin
                            mode_q[i]       = d[3:1];
                            bcd_q[i]        = d[0];
                            access_q[i]     = d[5:4];
                            load_pending[i] = 1'b1;
                            if (d[5:4] == tcit_pkg::ACC_WORD)
                                low_next[i] = 1'b1;
                        end
                    end
                end
                else if (rsel < NUM_COUNTERS)
                begin
                    i  = rsel;
                    lo = (access_q[i] == tcit_pkg::ACC_LOW) ||
                         (access_q[i] == tcit_pkg::ACC_WORD && low_next[i]);
                    if (access_q[i] == tcit_pkg::ACC_WORD)
                        low_next[i] = !low_next[i];
                    if (lo)
                        hold_q[i][7:0] = d;
                    else
                    begin
                        hold_q[i][15:8] = d;
                        reload_q[i]     = hold_q[i];
                        if (load_pending[i])
                        begin
                            count_q[i]      = {16'd0, reload_q[i] - 16'd1};
                            load_pending[i] = 1'b0;
                        end
                    end
                    move_out(i, mode_q[i] != tcit_pkg::MODE_INT_ON_TC);
                end
            end
            tcit_pkg::CMD_READ:
            begin
                if (rsel != tcit_pkg::REG_CONTROL && rsel < NUM_COUNTERS)
                begin
                    i   = rsel;
                    val = snap_valid[i] ? snap_q[i] : count_q[i][15:0];
                    lo  = (access_q[i] == tcit_pkg::ACC_LOW) ||
                          (access_q[i] == tcit_pkg::ACC_WORD && low_next[i]);
                    if (access_q[i] == tcit_pkg::ACC_WORD)
                        low_next[i] = !low_next[i];
                    if (access_q[i] == tcit_pkg::ACC_LOW)
                        snap_valid[i] = 1'b0;
                    if (lo)
                        r.rd_byte = val[7:0];
                    else
                    begin
                        snap_valid[i] = 1'b0;
                        r.rd_byte     = val[15:8];
                    end
                end
            end
            tcit_pkg::CMD_GATE:
            begin
                if (csel < NUM_COUNTERS)
                begin
                    i = csel;
                    m = mode_q[i];
                    if (m == tcit_pkg::MODE_INT_ON_TC || m == tcit_pkg::MODE_RATE_GEN ||
                        m == tcit_pkg::MODE_SQUARE)
                        running[i] = d[0];
                    else if ((m == tcit_pkg::MODE_ONE_SHOT || m == tcit_pkg::MODE_HW_STROBE)
                             && !gate_q[i] && d[0])
                        running[i] = 1'b1;
                    if ((m == tcit_pkg::MODE_RATE_GEN || m == tcit_pkg::MODE_SQUARE) && !d[0])
                        move_out(i, 1'b1);
                    if (!gate_q[i] && d[0])
                        count_q[i] = {16'd0, reload_q[i]};
                    gate_q[i] = d[0];
                end
            end
            default:
            begin
                if (ticks != 16'd0)
                begin
                    for (i = 0; i < NUM_COUNTERS; i++)
                    begin
                        m = mode_q[i];
                        if (running[i] && m >= tcit_pkg::MODE_SW_STROBE && !out_q[i])
                        begin
                            // end of the strobe pulse
                            move_out(i, 1'b1);
                            running[i] = 1'b0;
                            count_q[i] = tcit_pkg::STROBE_IDLE_COUNT;
                        end
                        else if (running[i])
                        begin
                            count_q[i] = count_q[i] - {16'd0, ticks};
                            if (m == tcit_pkg::MODE_SQUARE)
                                count_q[i] = count_q[i] - {16'd0, ticks};
                            if (count_q[i] == 32'd0 || count_q[i][31])
                            begin
                                count_q[i] = count_q[i] + ((reload_q[i] == 16'd0) ?
                                             32'd65536 : {16'd0, reload_q[i]});
                                if (m == tcit_pkg::MODE_INT_ON_TC ||
                                    m == tcit_pkg::MODE_ONE_SHOT)
                                    move_out(i, 1'b1);
                                else if (m == tcit_pkg::MODE_RATE_GEN)
                                    move_out(i, 1'b0);
                                else if (m == tcit_pkg::MODE_SQUARE)
                                    move_out(i, !out_q[i]);
                            end
                            else
                            begin
                                if (m == tcit_pkg::MODE_ONE_SHOT ||
                                    m == tcit_pkg::MODE_SW_STROBE ||
                                    m == tcit_pkg::MODE_HW_STROBE)
                                    move_out(i, 1'b0);
                                else if (m == tcit_pkg::MODE_RATE_GEN)
                                    move_out(i, 1'b1);
                            end
                        end
                    end
                end
            end
        endcase
        r.lvl0    = (NUM_COUNTERS > 0) && out_q[0];
        r.lvl1    = (NUM_COUNTERS > 1) && out_q[1];
        r.lvl2    = (NUM_COUNTERS > 2) && out_q[2];
        r.changed = changed_now;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            fails++;
        end
    endfunction

    initial
        fails = 0;

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                count_q[i]      = '0;
                reload_q[i]     = '0;
                hold_q[i]       = '0;
                snap_q[i]       = '0;
                snap_valid[i]   = 1'b0;
                mode_q[i]       = tcit_pkg::MODE_SQUARE;
                access_q[i]     = tcit_pkg::ACC_WORD;
                bcd_q[i]        = 1'b0;
                low_next[i]     = 1'b1;
                load_pending[i] = 1'b0;
                running[i]      = 1'b0;
                gate_q[i]       = 1'b0;
                out_q[i]        = 1'b0;
            end
            expected_results.delete();
            words_awaited <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected, read_data %0h", read_data);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.rd_byte, read_data);
                    check_field("out_level0", 8'(want.lvl0), 8'(out_level0));
                    check_field("out_level1", 8'(want.lvl1), 8'(out_level1));
                    check_field("out_level2", 8'(want.lvl2), 8'(out_level2));
                    check_field("out_changed", 8'(want.changed), 8'(out_changed));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(timer_predict(command, reg_select, data,
                                                         counter_select, tick_count));
            words_awaited <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// top of the interval timer testbench: stimulus, idling, verdict
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // counter field value 3 selects read-back or a counter that does not exist
    localparam logic [1:0] NO_COUNTER = 2'd3;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [1:0]  command        = tcit_pkg::CMD_READ;
    logic [1:0]  reg_select     = '0;
    logic [7:0]  data           = '0;
    logic [1:0]  counter_select = '0;
    logic [15:0] tick_count     = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  read_data;
    logic        out_level0;
    logic        out_level1;
    logic        out_level2;
    logic [2:0]  out_changed;

    int mismatch_count;
    int words_awaited;

    // idling odds in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;

    // words that do something, ignored ones are not counted
    int words_sent = 0;

    three_channel_interval_timer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .reg_select     (reg_select),
        .data           (data),
        .counter_select (counter_select),
        .tick_count     (tick_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .out_level0     (out_level0),
        .out_level1     (out_level1),
        .out_level2     (out_level2),
        .out_changed    (out_changed)
    );

    tcit_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .reg_select     (reg_select),
        .data           (data),
        .counter_select (counter_select),
        .tick_count     (tick_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .out_level0     (out_level0),
        .out_level1     (out_level1),
        .out_level2     (out_level2),
        .out_changed    (out_changed),
        .mismatch_count (mismatch_count),
        .words_awaited  (words_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side: stall at random with the odds of the current phase
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // hands one command word to the block, with random idle cycles in front;
    // called at a rising edge, returns at the edge that took the word
    task automatic put_word(input logic [1:0] cmd, input logic [1:0] rsel,
                            input logic [7:0] d, input logic [1:0] csel,
                            input logic [15:0] ticks);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        reg_select     <= rsel;
        data           <= d;
        counter_select <= csel;
        tick_count     <= ticks;
        do
            @(posedge clk);
        while (in_stall);
        // read-back control, absent counter gate, empty batch and control read do nothing
        if (!((cmd == tcit_pkg::CMD_WRITE && rsel == tcit_pkg::REG_CONTROL &&
               d[7:6] == NO_COUNTER) ||
              (cmd == tcit_pkg::CMD_GATE && csel == NO_COUNTER) ||
              (cmd == tcit_pkg::CMD_TICK && ticks == 16'd0) ||
              (cmd == tcit_pkg::CMD_READ && rsel == tcit_pkg::REG_CONTROL)))
            words_sent++;
    endtask

    // program one counter, load a count, start it, then exercise it;
    // now and then the high byte is left out to leave a broken load behind
    task automatic timer_sequence();
        logic [1:0]  ch;
        logic [1:0]  acc;
        logic [7:0]  ctrl;
        logic [7:0]  gd;
        logic [15:0] cnt;
        ch  = 2'($urandom_range(2));
        acc = 2'($urandom_range(tcit_pkg::ACC_LOW, tcit_pkg::ACC_WORD));
        // random mode and bcd bit, chosen counter and access
        ctrl      = 8'($urandom);
        ctrl[7:6] = ch;
        ctrl[5:4] = acc;
        case ($urandom_range(3))
            0:       cnt = 16'd0;
            1:       cnt = 16'($urandom);
            default: cnt = 16'($urandom_range(1, 40));
        endcase
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, ctrl, 2'($urandom),
                 16'($urandom));
        if (acc == tcit_pkg::ACC_LOW)
            put_word(tcit_pkg::CMD_WRITE, ch, cnt[7:0], 2'($urandom), 16'($urandom));
        else if (acc == tcit_pkg::ACC_HIGH)
            put_word(tcit_pkg::CMD_WRITE, ch, cnt[15:8], 2'($urandom), 16'($urandom));
        else
        begin
            put_word(tcit_pkg::CMD_WRITE, ch, cnt[7:0], 2'($urandom), 16'($urandom));
            if ($urandom_range(7) != 0)
                put_word(tcit_pkg::CMD_WRITE, ch, cnt[15:8], 2'($urandom), 16'($urandom));
        end
        // a rising gate loads the count, so lower it first half the time
        gd = 8'($urandom);
        if ($urandom_range(1) == 0)
        begin
            gd[0] = 1'b0;
            put_word(tcit_pkg::CMD_GATE, 2'($urandom), gd, ch, 16'($urandom));
        end
        gd    = 8'($urandom);
        gd[0] = 1'b1;
        put_word(tcit_pkg::CMD_GATE, 2'($urandom), gd, ch, 16'($urandom));
        repeat ($urandom_range(3, 14))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    put_word(tcit_pkg::CMD_TICK, 2'($urandom), 8'($urandom), 2'($urandom),
                             16'($urandom_range(1, 24)));
                4:
                    // any size, large ones drive the count deep below zero
                    put_word(tcit_pkg::CMD_TICK, 2'($urandom), 8'($urandom), 2'($urandom),
                             16'($urandom));
                5:
                    put_word(tcit_pkg::CMD_READ, ch, 8'($urandom), 2'($urandom),
                             16'($urandom));
                6:
                begin
                    ctrl      = 8'($urandom);
                    ctrl[7:6] = ch;
                    ctrl[5:4] = tcit_pkg::ACC_LATCH;
                    put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, ctrl, 2'($urandom),
                             16'($urandom));
                    put_word(tcit_pkg::CMD_READ, ch, 8'($urandom), 2'($urandom),
                             16'($urandom));
                    put_word(tcit_pkg::CMD_READ, ch, 8'($urandom), 2'($urandom),
                             16'($urandom));
                end
                7:
                    put_word(tcit_pkg::CMD_GATE, 2'($urandom), 8'($urandom), 2'($urandom),
                             16'($urandom));
                8:
                    put_word(tcit_pkg::CMD_WRITE, ch, 8'($urandom), 2'($urandom),
                             16'($urandom));
                default:
                    put_word(tcit_pkg::CMD_READ, 2'($urandom), 8'($urandom), 2'($urandom),
                             16'($urandom));
            endcase
        end
    endtask

    // mostly programmed sequences, about one pick in five a single word of pure noise
    task automatic run_phase(int target);
        while (words_sent < target)
        begin
            if ($urandom_range(4) == 0)
                put_word(2'($urandom), 2'($urandom), 8'($urandom), 2'($urandom),
                         16'($urandom));
            else
                timer_sequence();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first phase: sender idles a little, receiver stalls a lot
        idle_pct  = 9;
        stall_pct = 76;

        // directed words from the reset state
        // count low byte after reset, then high byte
        put_word(tcit_pkg::CMD_READ, 2'd0, 8'h00, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_READ, 2'd0, 8'h00, 2'd0, 16'd0);
        // control register reads zero
        put_word(tcit_pkg::CMD_READ, tcit_pkg::REG_CONTROL, 8'h00, 2'd0, 16'd0);
        // counter 0, rate generator, word
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'h34, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_WRITE, 2'd0, 8'h10, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_WRITE, 2'd0, 8'h00, 2'd0, 16'd0);     // commits a reload of 16
        put_word(tcit_pkg::CMD_GATE, 2'd0, 8'h01, 2'd0, 16'd0);      // gate rises, count reloads
        put_word(tcit_pkg::CMD_TICK, 2'd0, 8'h00, 2'd0, 16'd5);
        put_word(tcit_pkg::CMD_TICK, 2'd0, 8'h00, 2'd0, 16'd11);     // exact terminal count
        put_word(tcit_pkg::CMD_TICK, 2'd0, 8'h00, 2'd0, 16'd0);      // empty batch
        put_word(tcit_pkg::CMD_TICK, 2'd0, 8'h00, 2'd0, 16'hFFFF);   // deep underflow
        // latch counter 0, high byte read frees the latch
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'h00, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_READ, 2'd0, 8'hFF, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_READ, 2'd0, 8'hFF, 2'd0, 16'd0);
        // counter 1, one-shot, low only, bcd
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'h53, 2'd1, 16'd0);
        put_word(tcit_pkg::CMD_WRITE, 2'd1, 8'hFF, 2'd1, 16'd0);
        put_word(tcit_pkg::CMD_GATE, 2'd1, 8'hFF, 2'd1, 16'd0);
        // counter 2, hardware strobe, high
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'hAA, 2'd2, 16'd0);
        put_word(tcit_pkg::CMD_WRITE, 2'd2, 8'h80, 2'd2, 16'd0);
        put_word(tcit_pkg::CMD_GATE, 2'd3, 8'hFF, 2'd2, 16'd0);
        put_word(tcit_pkg::CMD_TICK, 2'd3, 8'hFF, 2'd3, 16'd1);      // strobe pulse goes low
        put_word(tcit_pkg::CMD_TICK, 2'd3, 8'hFF, 2'd3, 16'd1);      // and ends
        // mode 7 on counter 0, then a read-back word that is ignored
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'h3E, 2'd0, 16'd0);
        put_word(tcit_pkg::CMD_WRITE, tcit_pkg::REG_CONTROL, 8'hC0, 2'd0, 16'd0);
        // gate of an absent counter
        put_word(tcit_pkg::CMD_GATE, 2'd0, 8'h01, NO_COUNTER, 16'd0);

        run_phase(550);

        // second phase: the other way round
        idle_pct  = 76;
        stall_pct = 9;
        run_phase(1100);

        // last phase: full rate on both sides
        idle_pct  = 0;
        stall_pct = 0;
        run_phase(1650);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_awaited != 0);
        // let the input and result registers drain, with some margin
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== three_channel_interval_timer_core.f =====
hw/rtl/tcit_pkg.sv
hw/rtl/tcit_counter.sv
hw/rtl/three_channel_interval_timer_core.sv
hw/rtl/tcit_checker.sv
tb/sv/tcit_result_checker.sv
tb/sv/testbench.sv
